// ----- src/cre_pkg.sv -----
`default_nettype none
package cre_pkg;

  localparam int unsigned POSITION_WIDTH = 32;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam logic [7:0] CHAR_X       = 8'h58;
  localparam logic [7:0] CHAR_M       = 8'h4D;
  localparam logic [7:0] CHAR_D       = 8'h44;
  localparam logic [7:0] CHAR_I       = 8'h49;
  localparam logic [7:0] CHAR_S       = 8'h53;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] PHRED_OFFSET = 8'd33;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_BASE  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_BASE       = 2'd0,
    STATUS_NO_OP      = 2'd1,
    STATUS_OP_PENDING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ITEM_START = 2'd0,
    ITEM_OP    = 2'd1,
    ITEM_BASE  = 2'd2
  } item_e;

  typedef enum logic [1:0] {
    OP_M = 2'd0,
    OP_D = 2'd1,
    OP_I = 2'd2,
    OP_S = 2'd3
  } op_e;

  // One classified word handed from the front to the back.
  typedef struct packed {
    item_e       kind;
    op_e         op;
    logic [31:0] value;
    logic [7:0]  base;
  } item_t;

  function automatic logic [7:0] upper_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h5B:8'h7F]}) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/cre_front.sv -----
`default_nettype none
module cre_front import cre_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] position_i,
  input  wire logic [7:0]  char_i,
  input  wire logic [7:0]  qual_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output item_t            q_item_o
);

  logic [6:0]  threshold_q;
  logic [31:0] acc_q, acc_d;
  logic        accept;
  logic        is_digit;
  logic [35:0] acc_x10;
  logic [31:0] acc_sat;
  logic [7:0]  op_char;
  logic [7:0]  qual_limit;
  logic        low_quality;
  logic        push;
  item_t       item;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_digit    = char_i inside {[CHAR_ZERO:CHAR_NINE]};
    acc_x10     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                  + {32'b0, 4'(char_i - CHAR_ZERO)};
    acc_sat     = (|acc_x10[35:32]) ? '1 : acc_x10[31:0];
    op_char     = upper_byte(char_i);
    // A quality below 33 gives a negative phred value, which is always low.
    qual_limit  = {1'b0, threshold_q} + PHRED_OFFSET;
    low_quality = (qual_i != CHAR_STAR) && (qual_i < qual_limit);

    acc_d      = acc_q;
    push       = 1'b0;
    item.kind  = ITEM_OP;
    item.op    = OP_M;
    item.value = acc_q;
    item.base  = low_quality ? CHAR_X : op_char;

    case (cmd_e'(cmd_i))
      CMD_START: begin
        push       = 1'b1;
        item.kind  = ITEM_START;
        item.value = position_i;
        acc_d      = '0;
      end
      CMD_CHAR: begin
        if (is_digit) begin
          acc_d = acc_sat;
        end else begin
          acc_d = '0;
          push  = 1'b1;
          case (op_char)
            CHAR_M:  item.op = OP_M;
            CHAR_D:  item.op = OP_D;
            CHAR_I:  item.op = OP_I;
            CHAR_S:  item.op = OP_S;
            default: push = 1'b0;
          endcase
        end
      end
      CMD_BASE: begin
        push      = 1'b1;
        item.kind = ITEM_BASE;
      end
      default: push = 1'b0;
    endcase
  end

  assign q_push_o = accept && push;
  assign q_item_o = item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      acc_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        threshold_q <= cfg_data_i;
      end
      if (accept) begin
        acc_q <= acc_d;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/cre_queue.sv -----
`default_nettype none
module cre_queue import cre_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = store_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("queue count beyond its depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("word pushed into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("word popped from an empty queue");

endmodule
`default_nettype wire

// ----- src/cre_back.sv -----
`default_nettype none
module cre_back import cre_pkg::*; #(
  parameter int unsigned PositionWidth = POSITION_WIDTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  wire item_t        q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [31:0]       out_position_o,
  output logic [7:0]        out_base_o,
  output logic [1:0]        out_status_o
);

  logic [PositionWidth-1:0] pos_q, pos_d;
  logic [31:0]              count_q, count_d;
  logic                     aligned_q, aligned_d;
  logic                     begun_q, begun_d;
  logic                     out_valid_q;
  logic [31:0]              out_pos_q;
  logic [7:0]               out_base_q;
  status_e                  out_status_q;
  logic                     advance, pop;
  logic                     emit;
  logic [7:0]               emit_base;
  status_e                  emit_status;

  // The result register is free, or is being emptied in this cycle.
  assign advance = !out_valid_q || out_ready_i;
  assign pop     = q_valid_i && advance;
  assign q_pop_o = pop;

  always_comb begin
    pos_d       = pos_q;
    count_d     = count_q;
    aligned_d   = aligned_q;
    begun_d     = begun_q;
    emit        = 1'b0;
    emit_base   = '0;
    emit_status = STATUS_BASE;

    case (q_item_i.kind)
      ITEM_START: begin
        pos_d     = PositionWidth'(q_item_i.value);
        count_d   = '0;
        aligned_d = 1'b0;
        begun_d   = 1'b0;
      end
      ITEM_OP: begin
        // Bases still owed to the previous op are dropped and reported.
        if (count_q != '0) begin
          emit        = 1'b1;
          emit_status = STATUS_OP_PENDING;
        end
        count_d = '0;
        case (q_item_i.op)
          OP_M: begin
            begun_d   = 1'b1;
            count_d   = q_item_i.value;
            aligned_d = 1'b1;
          end
          OP_D: pos_d = pos_q + PositionWidth'(q_item_i.value);
          OP_I: begin
            count_d   = q_item_i.value;
            aligned_d = 1'b0;
          end
          OP_S: begin
            count_d   = q_item_i.value;
            aligned_d = 1'b0;
            if (begun_q) begin
              pos_d = pos_q + PositionWidth'(q_item_i.value);
            end
          end
          default: count_d = '0;
        endcase
      end
      ITEM_BASE: begin
        if (count_q == '0) begin
          emit        = 1'b1;
          emit_status = STATUS_NO_OP;
        end else begin
          count_d = count_q - 1'b1;
          if (aligned_q) begin
            emit      = 1'b1;
            emit_base = q_item_i.base;
            pos_d     = pos_q + 1'b1;
          end
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      count_q     <= '0;
      aligned_q   <= 1'b0;
      begun_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        pos_q     <= pos_d;
        count_q   <= count_d;
        aligned_q <= aligned_d;
        begun_q   <= begun_d;
      end
      if (advance) begin
        out_valid_q <= pop && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      out_pos_q    <= 32'(pos_q);
      out_base_q   <= emit_base;
      out_status_q <= emit_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_position_o = out_pos_q;
  assign out_base_o     = out_base_q;
  assign out_status_o   = out_status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !out_ready_i) |-> !q_pop_o)
    else $error("queue popped while the result register is blocked");

endmodule
`default_nettype wire

// ----- src/cigar_read_expander.sv -----
`default_nettype none
// Expands one aligned read by its CIGAR string into pairs of reference position and base.
// The input stream carries the command in s_axis_tuser (start, CIGAR character, base) and
// the results leave on the master side with the status in m_axis_tuser. Every input word
// is taken unless the queue is full: the front accumulates digits, decodes op letters,
// computes the quality test and places each item in a four-entry queue; the back takes
// one queued item per cycle unless the result register is blocked, updates the position
// and pending-base count and loads any result. Only a result-side stall fills the queue.
// The quality threshold is written through the cfg port, one word, no address.
module cigar_read_expander import cre_pkg::*; #(
  parameter int unsigned PositionWidth = POSITION_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i,     // min_quality
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // start_position, char_in, quality_char
  input  wire logic [1:0]  s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // ref_position, base_out
  output logic [1:0]       m_axis_tuser    // status
);

  logic  q_push, q_full, q_valid, q_pop;
  item_t push_item, pop_item;

  assign cfg_ready_o = 1'b1;

  cre_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .position_i  (s_axis_tdata[31:0]),
    .char_i      (s_axis_tdata[39:32]),
    .qual_i      (s_axis_tdata[47:40]),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (push_item)
  );

  cre_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  cre_back #(
    .PositionWidth (PositionWidth)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (pop_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_position_o (m_axis_tdata[31:0]),
    .out_base_o     (m_axis_tdata[39:32]),
    .out_status_o   (m_axis_tuser)
  );

endmodule
`default_nettype wire
